FILE: rtl/core/multi_stack_pool_top_macros.svh
// Assertion macros for the stack pool.
// No dependencies; included by files that carry assertions.
`ifndef MULTI_STACK_POOL_TOP_MACROS_SVH
`define MULTI_STACK_POOL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MSP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSP_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define MSP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/msp_pkg.sv
// Shared types and codes for the stack pool.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msp_pkg;

    // Fixed field widths of the request and result words.
    localparam int REQ_TYPE_W   = 3;
    localparam int HANDLE_W     = 3;
    localparam int PUSH_VALUE_W = 32;
    localparam int LIMIT_W      = 8;
    localparam int TOP_VALUE_W  = 32;
    localparam int DEPTH_NOW_W  = 7;
    localparam int STATUS_W     = 2;

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_NEW    = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH   = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP    = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_TOP    = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_DETACH = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSLOT   = 2'd3;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]     req_type;
        logic [HANDLE_W-1:0]       handle;
        logic [PUSH_VALUE_W-1:0]   push_value;
        logic signed [LIMIT_W-1:0] capacity_limit;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0]    new_handle;
        logic [TOP_VALUE_W-1:0] top_value;
        logic [DEPTH_NOW_W-1:0] depth_now;
        logic                   is_empty;
        logic [STATUS_W-1:0]    status;
    } t_rsp;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

endpackage

FILE: rtl/core/msp_ctrl.sv
// Controller state machine for the stack pool: handshakes and sequencing.
// Depends on msp_pkg.
`timescale 1ns / 1ps

module msp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msp_pkg::t_ctrl_cmd o_cmd
);
    import msp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // The output register may be reloaded when empty or being taken.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.commit = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // State and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/msp_datapath.sv
// Datapath of the stack pool: slot table, entry memory and result register.
// Depends on msp_pkg; sequenced by msp_ctrl.
`timescale 1ns / 1ps

module msp_datapath #(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msp_pkg::t_ctrl_cmd i_cmd,
    input  msp_pkg::t_req      i_req,
    output msp_pkg::t_rsp      o_rsp
);
    import msp_pkg::*;

    localparam int SW        = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int DAW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW        = $clog2(STACK_DEPTH + 1);
    localparam int AW        = SW + DAW;
    localparam int MEM_DEPTH = 2 ** AW;

    // Slot table.
    logic [NUM_STACKS-1:0] r_slot_in_use;
    logic [LIMIT_W-1:0]    r_slot_limit [NUM_STACKS];
    logic [CW-1:0]         r_slot_count [NUM_STACKS];

    // Entry memory.
    logic [DATA_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // Request captured at accept, with the addressed slot's state.
    t_req               r_req;
    logic               r_live;
    logic [SW-1:0]      r_idx;
    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_limit;
    t_rsp               r_rsp;

    logic [SW-1:0]         w_idx;
    logic                  w_live;
    logic [CW-1:0]         w_cnt_sel;
    logic [AW-1:0]         w_rd_addr;
    logic [NUM_STACKS-1:0] w_free;
    logic [NUM_STACKS-1:0] w_onehot;
    logic [SW-1:0]         w_new_slot;
    logic                  w_found;
    logic [CW-1:0]         w_eff_limit;
    logic [CW-1:0]         w_depth;
    logic [DATA_WIDTH-1:0] w_wr_data;
    t_rsp                  n_rsp;
    logic                  w_upd_en;
    logic [SW-1:0]         w_upd_idx;
    logic                  w_upd_in_use;
    logic [LIMIT_W-1:0]    w_upd_limit;
    logic [CW-1:0]         w_upd_count;
    logic                  w_mem_we;

    // Addressed slot and the read address of its top entry.
    assign w_idx     = SW'(i_req.handle);
    assign w_live    = (int'(i_req.handle) < NUM_STACKS) && r_slot_in_use[w_idx];
    assign w_cnt_sel = r_slot_count[w_idx];
    assign w_rd_addr = {w_idx, DAW'(w_cnt_sel - CW'(1))};

    // Lowest free slot, isolated as a one-hot word and then encoded.
    assign w_free   = ~r_slot_in_use;
    assign w_onehot = w_free & (~w_free + NUM_STACKS'(1));
    assign w_found  = |w_free;

    always_comb begin
        w_new_slot = '0;
        for (int i = 0; i < NUM_STACKS; i++) begin
            w_new_slot = w_new_slot | (w_onehot[i] ? SW'(i) : SW'(0));
        end
    end

    // A negative limit or one beyond the physical depth means the full depth.
    always_comb begin
        if (r_limit[LIMIT_W-1] || (int'(r_limit[LIMIT_W-2:0]) > STACK_DEPTH)) begin
            w_eff_limit = CW'(STACK_DEPTH);
        end else begin
            w_eff_limit = CW'(r_limit[LIMIT_W-2:0]);
        end
    end

    assign w_wr_data = DATA_WIDTH'(r_req.push_value);

    // Execute the captured request against the captured slot state.
    always_comb begin
        n_rsp        = '0;
        w_depth      = '0;
        w_upd_en     = 1'b0;
        w_upd_idx    = r_idx;
        w_upd_in_use = 1'b1;
        w_upd_limit  = r_limit;
        w_upd_count  = r_count;
        w_mem_we     = 1'b0;
        n_rsp.status = ST_OK;
        if (r_req.req_type == REQ_NEW) begin
            if (w_found) begin
                w_upd_en         = 1'b1;
                w_upd_idx        = w_new_slot;
                w_upd_limit      = r_req.capacity_limit;
                w_upd_count      = '0;
                n_rsp.new_handle = HANDLE_W'(w_new_slot);
            end else begin
                n_rsp.status = ST_NOSLOT;
            end
        end else if (!r_live) begin
            // A free or absent slot changes nothing.
            if (r_req.req_type == REQ_PUSH) begin
                n_rsp.status = ST_OVERFLOW;
            end else if (r_req.req_type == REQ_POP || r_req.req_type == REQ_TOP) begin
                n_rsp.status = ST_EMPTY;
            end
        end else begin
            w_depth = r_count;
            priority case (r_req.req_type)
                REQ_PUSH: begin
                    if (r_count >= w_eff_limit) begin
                        n_rsp.status = ST_OVERFLOW;
                    end else begin
                        w_mem_we    = 1'b1;
                        w_upd_en    = 1'b1;
                        w_upd_count = r_count + CW'(1);
                        w_depth     = w_upd_count;
                    end
                end
                REQ_POP: begin
                    if (r_count == '0) begin
                        n_rsp.status = ST_EMPTY;
                    end else begin
                        w_upd_en    = 1'b1;
                        w_upd_count = r_count - CW'(1);
                        w_depth     = w_upd_count;
                    end
                end
                REQ_TOP: begin
                    if (r_count == '0) begin
                        n_rsp.status = ST_EMPTY;
                    end else begin
                        n_rsp.top_value = TOP_VALUE_W'(r_rd_data);
                    end
                end
                REQ_DETACH: begin
                    w_upd_en     = 1'b1;
                    w_upd_in_use = 1'b0;
                    w_upd_count  = '0;
                    w_depth      = '0;
                end
                default: begin
                    // Unknown requests only report the depth.
                    w_upd_en = 1'b0;
                end
            endcase
        end
        n_rsp.depth_now = DEPTH_NOW_W'(w_depth);
        n_rsp.is_empty  = (w_depth == '0);
    end

    // Capture the request and read the top entry on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req     <= i_req;
            r_live    <= w_live;
            r_idx     <= w_idx;
            r_count   <= w_cnt_sel;
            r_limit   <= r_slot_limit[w_idx];
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Entry memory write for a successful push.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_mem_we) begin
            r_mem[{r_idx, DAW'(r_count)}] <= w_wr_data;
        end
    end

    // Slot table update on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_in_use <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_slot_limit[i] <= '0;
                r_slot_count[i] <= '0;
            end
        end else if (i_cmd.commit && w_upd_en) begin
            r_slot_in_use[w_upd_idx] <= w_upd_in_use;
            r_slot_limit[w_upd_idx]  <= w_upd_limit;
            r_slot_count[w_upd_idx]  <= w_upd_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

FILE: rtl/core/multi_stack_pool_top.sv
// The result word and its valid flag are registered on commit, which waits while
// the last result is not taken. No request is accepted until the last one commits:
// the entry memory port captures and reads, then the execute step updates the
// slot table. Reset clears the slot table but not the entry memory.
// Depends on msp_pkg, msp_ctrl, msp_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_stack_pool_top_macros.svh"

module multi_stack_pool_top #(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msp_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output msp_pkg::t_rsp o_out_data
);
    import msp_pkg::*;

    t_ctrl_cmd w_cmd;

    // Sequencing and handshakes.
    msp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Slot table, entry memory and result register.
    msp_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_data),
        .o_rsp   (o_out_data)
    );

    // Checks on sequencing.
    `MSP_ASSERT_RST(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input accepted while a word is in flight")
    `MSP_ASSERT_RST(a_commit_valid, i_clk, i_rst_n, w_cmd.commit |=> o_out_valid, "result word not presented after commit")
    `MSP_ASSERT_RST(a_no_double_capture, i_clk, i_rst_n, w_cmd.capture |=> !w_cmd.capture, "capture in two consecutive cycles")
    `MSP_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid straight after reset")

endmodule

FILE: sim/multi_stack_pool_top_test.sv
// Self-checking testbench for the stack pool: directed table then random requests.
// Depends on msp_pkg and multi_stack_pool_top; results are checked by an in-bench model.
`timescale 1ns / 1ps

module multi_stack_pool_top_test;

    import msp_pkg::*;

    localparam int NUM_STACKS    = 8;
    localparam int STACK_DEPTH   = 64;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int CALM_ITEMS    = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;

    // Request codes that the block ignores.
    localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_A = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_B = 3'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_C = 3'd7;

    typedef struct {
        t_req word;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic o_in_ready;
    t_req in_data;
    logic o_out_valid;
    logic out_ready;
    t_rsp o_out_data;

    // Model of the pool: slot table and entry words.
    logic              slot_busy  [NUM_STACKS];
    logic signed [7:0] slot_cap   [NUM_STACKS];
    int unsigned       slot_depth [NUM_STACKS];
    logic [31:0]       slot_words [NUM_STACKS][STACK_DEPTH];

    t_rsp pending_rsp[$];
    t_row dir_rows[$];
    int   mismatches   = 0;
    int   rsp_seen     = 0;
    int   stall_cycles = 0;
    bit   calm         = 1'b0;
    bit   hold_wanted  = 1'b0;

    multi_stack_pool_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // A negative limit, or one above the physical depth, means the full depth.
    function automatic int unsigned cap_entries(input logic signed [7:0] cap);
        int c;
        c = int'(cap);
        if (c < 0 || c > STACK_DEPTH) return STACK_DEPTH;
        return c;
    endfunction

    // Applies one request to the model and returns the result word it gives.
    function automatic t_rsp pool_response(input t_req w);
        t_rsp        rsp;
        int          slot;
        int unsigned h;
        logic        live;
        rsp  = '0;
        h    = 32'(w.handle);
        live = slot_busy[h];
        slot = -1;
        case (w.req_type)
            REQ_NEW: begin
                for (int i = NUM_STACKS - 1; i >= 0; i--) if (!slot_busy[i]) slot = i;
                if (slot < 0) begin
                    rsp.status = ST_NOSLOT;
                end else begin
                    slot_busy[slot]  = 1'b1;
                    slot_cap[slot]   = w.capacity_limit;
                    slot_depth[slot] = 0;
                    rsp.new_handle   = 3'(slot);
                end
            end
            REQ_PUSH: begin
                if (!live || slot_depth[h] >= cap_entries(slot_cap[h])) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    slot_words[h][slot_depth[h]] = w.push_value;
                    slot_depth[h]++;
                end
            end
            REQ_POP, REQ_TOP: begin
                if (!live || slot_depth[h] == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (w.req_type == REQ_POP) begin
                    slot_depth[h]--;
                end else begin
                    rsp.top_value = slot_words[h][slot_depth[h] - 1];
                end
            end
            REQ_DETACH: begin
                if (live) begin
                    slot_depth[h] = 0;
                    slot_busy[h]  = 1'b0;
                end
            end
            default: ;
        endcase
        if (w.req_type != REQ_NEW && live) rsp.depth_now = 7'(slot_depth[h]);
        rsp.is_empty = (rsp.depth_now == 0);
        return rsp;
    endfunction

    function automatic t_req mk_req(input logic [2:0] req, input logic [2:0] h,
                                    input logic [31:0] v, input logic [7:0] lim);
        t_req w;
        w.req_type       = req;
        w.handle         = h;
        w.push_value     = v;
        w.capacity_limit = lim;
        return w;
    endfunction

    // Table row whose result is worked out by the model.
    function automatic t_row row_p(input logic [2:0] req, input logic [2:0] h,
                                   input logic [31:0] v, input logic [7:0] lim);
        t_row r;
        r.word  = mk_req(req, h, v, lim);
        r.typed = 1'b0;
        r.rsp   = '0;
        return r;
    endfunction

    // Table row with its result written out.
    function automatic t_row row_k(input logic [2:0] req, input logic [2:0] h,
                                   input logic [31:0] v, input logic [7:0] lim,
                                   input logic [2:0] nh, input logic [31:0] tv,
                                   input logic [6:0] d, input logic [1:0] st);
        t_row r;
        r.word           = mk_req(req, h, v, lim);
        r.typed          = 1'b1;
        r.rsp.new_handle = nh;
        r.rsp.top_value  = tv;
        r.rsp.depth_now  = d;
        r.rsp.is_empty   = (d == 0);
        r.rsp.status     = st;
        return r;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Mostly a live handle, sometimes any handle at all.
    function automatic logic [2:0] pick_handle();
        logic [2:0] live_list[$];
        for (int i = 0; i < NUM_STACKS; i++) begin
            if (slot_busy[i]) live_list.insert(live_list.size(), 3'(i));
        end
        if (live_list.size() == 0 || $urandom_range(0, 99) < 15) return 3'($urandom_range(0, 7));
        return live_list[$urandom_range(0, live_list.size() - 1)];
    endfunction

    function automatic logic [7:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return 8'hFF;
            1: return 8'($urandom_range(0, STACK_DEPTH));
            2: return 8'($urandom);
            default: return 8'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result word %0d: %s got %0h, expected %0h",
                 rsp_seen, field, got, want);
        mismatches++;
    endtask

    // Offers one request word, entered and left at a falling edge.
    task automatic send_word(input t_req w, input bit typed, input t_rsp typed_rsp,
                             input bit gaps);
        t_rsp got;
        if (gaps && !calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        got = pool_response(w);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : got);
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure bursts, plus one long hold-off on request.
    initial begin
        int  rx_span;
        bit  rx_gaps;
        rx_span = 0;
        rx_gaps = 1'b0;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_span == 0) begin
                rx_span = 150;
                rx_gaps = ($urandom_range(0, 2) != 0);
            end
            rx_span--;
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                out_ready <= 1'b1;
            end else if (rx_gaps && !calm && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Result checker: each word against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("word with nothing expected, status",
                                32'(o_out_data.status), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.new_handle !== want.new_handle)
                    report_mismatch("new_handle", 32'(o_out_data.new_handle),
                                    32'(want.new_handle));
                if (o_out_data.top_value !== want.top_value)
                    report_mismatch("top_value", o_out_data.top_value, want.top_value);
                if (o_out_data.depth_now !== want.depth_now)
                    report_mismatch("depth_now", 32'(o_out_data.depth_now),
                                    32'(want.depth_now));
                if (o_out_data.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(o_out_data.is_empty),
                                    32'(want.is_empty));
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
            end
            rsp_seen++;
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_req       w;
        int         pick;
        int         burst_left;
        logic [2:0] burst_handle;
        bit         tx_gaps;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        for (int i = 0; i < NUM_STACKS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_cap[i]   = '0;
            slot_depth[i] = 0;
            for (int j = 0; j < STACK_DEPTH; j++) slot_words[i][j] = '0;
        end

        // Directed part: free slots, limit extremes, word extremes, full pool.
        add_row(row_k(REQ_TOP,    3'd0, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_EMPTY));
        add_row(row_k(REQ_PUSH,   3'd7, 32'hFFFFFFFF, 8'hFF, 3'd0, 32'd0, 7'd0, ST_OVERFLOW));
        add_row(row_k(REQ_POP,    3'd3, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_EMPTY));
        add_row(row_k(REQ_DETACH, 3'd5, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_RSVD_C, 3'd7, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_PUSH,   3'd0, 32'd1, 8'h00, 3'd0, 32'd0, 7'd0, ST_OVERFLOW));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'hFF, 3'd1, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_PUSH,   3'd1, 32'hFFFFFFFF, 8'h00, 3'd0, 32'd0, 7'd1, ST_OK));
        add_row(row_k(REQ_TOP,    3'd1, 32'd0, 8'h00, 3'd0, 32'hFFFFFFFF, 7'd1, ST_OK));
        add_row(row_k(REQ_PUSH,   3'd1, 32'd0, 8'h00, 3'd0, 32'd0, 7'd2, ST_OK));
        add_row(row_k(REQ_TOP,    3'd1, 32'hFFFFFFFF, 8'hFF, 3'd0, 32'd0, 7'd2, ST_OK));
        add_row(row_k(REQ_POP,    3'd1, 32'd0, 8'h00, 3'd0, 32'd0, 7'd1, ST_OK));
        add_row(row_k(REQ_POP,    3'd1, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_POP,    3'd1, 32'd0, 8'h00, 3'd0, 32'd0, 7'd0, ST_EMPTY));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'h7F, 3'd2, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'h80, 3'd3, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'd64, 3'd4, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'd1,  3'd5, 32'd0, 7'd0, ST_OK));
        add_row(row_p(REQ_PUSH,   3'd5, 32'hA5A5A5A5, 8'h00));
        add_row(row_p(REQ_PUSH,   3'd5, 32'h5A5A5A5A, 8'h00));
        add_row(row_p(REQ_RSVD_A, 3'd5, 32'h0,        8'h00));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'd65, 3'd6, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'd2,  3'd7, 32'd0, 7'd0, ST_OK));
        add_row(row_k(REQ_NEW,    3'd0, 32'd0, 8'd3,  3'd0, 32'd0, 7'd0, ST_NOSLOT));
        add_row(row_p(REQ_DETACH, 3'd5, 32'd0,        8'h00));
        add_row(row_p(REQ_NEW,    3'd0, 32'd0,        8'd5));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].rsp, 1'b1);

        // Random part: mostly requests on live stacks, with runs of pushes on one stack that
        // can fill it to its limit, and some noise on free slots.
        burst_left   = 0;
        burst_handle = '0;
        tx_gaps      = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) tx_gaps = ($urandom_range(0, 2) != 0);
            if (n == 400) hold_wanted = 1'b1;
            if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            w = mk_req(REQ_PUSH, pick_handle(), $urandom, 8'($urandom));
            if (burst_left == 0 && $urandom_range(0, 99) < 2) begin
                burst_left   = $urandom_range(20, 70);
                burst_handle = pick_handle();
            end
            if (burst_left > 0) begin
                burst_left--;
                w.handle = burst_handle;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) w.req_type = REQ_PUSH;
                else if (pick < 63) w.req_type = REQ_POP;
                else if (pick < 75) w.req_type = REQ_TOP;
                else if (pick < 85) begin
                    w.req_type       = REQ_NEW;
                    w.capacity_limit = pick_limit();
                end else if (pick < 93) w.req_type = REQ_DETACH;
                else w.req_type = REQ_RSVD_A + 3'($urandom_range(0, 2));
            end
            send_word(w, 1'b0, '0, tx_gaps);
        end
        in_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: multi_stack_pool_top.f
+incdir+rtl/core
rtl/core/msp_pkg.sv
rtl/core/msp_ctrl.sv
rtl/core/msp_datapath.sv
rtl/core/multi_stack_pool_top.sv
sim/multi_stack_pool_top_test.sv
